FILE: sv/hbc_pkg.sv
// Package for the sensor history buffer: word types, operation and status codes,
// controller states and the command bundle between controller and datapath.
// Depends on nothing; every other file imports it.
package hbc_pkg;

  // Fixed field widths of the channel words.
  localparam int ID_W   = 16;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;

  // Operation codes; codes beyond the list behave as show.
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_NEWER  = 3'd1,
    OP_OLDER  = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SHOW   = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_AT_END  = 2'd2,
    STS_EVICTED = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } state_t;

  // One stored sensor record.
  typedef struct packed {
    logic        [ID_W-1:0]   node_id;
    logic signed [DATA_W-1:0] temperature;
    logic signed [DATA_W-1:0] humidity;
    logic signed [DATA_W-1:0] pressure;
    logic signed [DATA_W-1:0] vibration;
    logic        [DATA_W-1:0] stamp;
  } rec_t;

  // Input word.
  typedef struct packed {
    logic        [2:0]        operation;
    logic        [ID_W-1:0]   node_id;
    logic signed [DATA_W-1:0] temperature;
    logic signed [DATA_W-1:0] humidity;
    logic signed [DATA_W-1:0] pressure;
    logic signed [DATA_W-1:0] vibration;
    logic        [DATA_W-1:0] stamp;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic        [1:0]        status;
    logic                     has_record;
    logic        [ID_W-1:0]   cur_node_id;
    logic signed [DATA_W-1:0] cur_temperature;
    logic signed [DATA_W-1:0] cur_humidity;
    logic signed [DATA_W-1:0] cur_pressure;
    logic signed [DATA_W-1:0] cur_vibration;
    logic        [DATA_W-1:0] cur_stamp;
    logic        [POS_W-1:0]  position;
    logic        [POS_W-1:0]  record_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input word
    logic exec;     // apply the operation to pointers and store
    logic read;     // read the record under the cursor
    logic load;     // load the result register
  } hbc_cmd_t;

endpackage

FILE: sv/hbc_if.sv
// Channel interfaces of the sensor history buffer: input words and result words,
// each with valid, ready and payload. Depends on hbc_pkg.

interface hbc_in_if import hbc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hbc_out_if import hbc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/hbc_ctrl.sv
// Controller of the sensor history buffer: sequences accept, update, record read
// and result load, and owns the result valid flag. Depends on hbc_pkg.
module hbc_ctrl import hbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output hbc_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register may be reloaded once its word is gone or leaves now.
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // State and valid flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/hbc_dpath.sv
// Datapath of the sensor history buffer: ring pointers, record memory and result
// register, driven by the controller's commands. Depends on hbc_pkg.
module hbc_dpath import hbc_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  hbc_cmd_t  cmd,
  input  in_word_t  in_word,
  output out_word_t out_word
);

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int WIDE_W = CNT_W + POS_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0]  CAP_SUM   = SUM_W'(CAPACITY);

  in_word_t          item_r;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  status_t           status_r, status_nxt;
  rec_t              rd_q;
  out_word_t         res_r;

  rec_t              mem [CAPACITY];
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  rec_t              wr_data;

  logic [SLOT_W-1:0] oldest_inc, cursor_inc, cursor_dec;
  logic [SUM_W-1:0]  tail_sum, newest_sum;
  logic [SLOT_W-1:0] tail_slot, newest_slot;
  logic              empty, full;
  logic [CNT_W-1:0]  ring_gap, pos_cnt;
  logic [WIDE_W-1:0] pos_wide, cnt_wide;

  // Step a slot number round the ring.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  // Bring a sum below twice the capacity back into the ring.
  function automatic logic [SLOT_W-1:0] sum_wrap(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] w;
    w = (v >= CAP_SUM) ? v - CAP_SUM : v;
    return w[SLOT_W-1:0];
  endfunction

  assign empty       = (held_r == '0);
  assign full        = (held_r == CAP_CNT);
  assign oldest_inc  = slot_inc(oldest_r);
  assign cursor_inc  = slot_inc(cursor_r);
  assign cursor_dec  = slot_dec(cursor_r);
  assign tail_sum    = SUM_W'(oldest_r) + SUM_W'(held_r);
  assign newest_sum  = tail_sum - 1'b1;
  assign tail_slot   = sum_wrap(tail_sum);
  assign newest_slot = sum_wrap(newest_sum);

  assign wr_data.node_id     = item_r.node_id;
  assign wr_data.temperature = item_r.temperature;
  assign wr_data.humidity    = item_r.humidity;
  assign wr_data.pressure    = item_r.pressure;
  assign wr_data.vibration   = item_r.vibration;
  assign wr_data.stamp       = item_r.stamp;

  // Operation decode: new pointers, status and the store write.
  always_comb begin
    oldest_nxt = oldest_r;
    cursor_nxt = cursor_r;
    held_nxt   = held_r;
    status_nxt = STS_OK;
    wr_en      = 1'b0;
    wr_addr    = oldest_r;
    case (item_r.operation)
      OP_APPEND: begin
        wr_en = 1'b1;
        if (empty) begin
          cursor_nxt = oldest_r;
          held_nxt   = CNT_W'(1);
        end else if (!full) begin
          wr_addr  = tail_slot;
          held_nxt = held_r + 1'b1;
        end else begin
          // Full ring: overwrite the oldest and drag the cursor along if it sat there.
          if (cursor_r == oldest_r) begin
            cursor_nxt = oldest_inc;
          end
          oldest_nxt = oldest_inc;
          status_nxt = STS_EVICTED;
        end
      end
      OP_NEWER: begin
        if (empty) begin
          status_nxt = STS_EMPTY;
        end else if (cursor_r == newest_slot) begin
          status_nxt = STS_AT_END;
        end else begin
          cursor_nxt = cursor_inc;
        end
      end
      OP_OLDER: begin
        if (empty) begin
          status_nxt = STS_EMPTY;
        end else if (cursor_r == oldest_r) begin
          status_nxt = STS_AT_END;
        end else begin
          cursor_nxt = cursor_dec;
        end
      end
      OP_CLEAR: begin
        oldest_nxt = '0;
        cursor_nxt = '0;
        held_nxt   = '0;
      end
      default: begin
        if (empty) begin
          status_nxt = STS_EMPTY;
        end
      end
    endcase
  end

  // Input word latch.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_word;
    end
  end

  // Ring pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      cursor_r <= '0;
      held_r   <= '0;
    end else if (cmd.exec) begin
      oldest_r <= oldest_nxt;
      cursor_r <= cursor_nxt;
      held_r   <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
  end

  // Record memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_q <= mem[cursor_r];
    end
  end

  // Cursor distance from the oldest record, taken modulo the capacity.
  always_comb begin
    if (cursor_r >= oldest_r) begin
      ring_gap = CNT_W'(cursor_r - oldest_r);
    end else begin
      ring_gap = CNT_W'(cursor_r) + CAP_CNT - CNT_W'(oldest_r);
    end
    pos_cnt  = ring_gap + 1'b1;
    pos_wide = WIDE_W'(pos_cnt);
    cnt_wide = WIDE_W'(held_r);
  end

  // Result register; an empty ring reports zeros for the record fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r.status          <= status_r;
      res_r.has_record      <= !empty;
      res_r.cur_node_id     <= empty ? '0 : rd_q.node_id;
      res_r.cur_temperature <= empty ? '0 : rd_q.temperature;
      res_r.cur_humidity    <= empty ? '0 : rd_q.humidity;
      res_r.cur_pressure    <= empty ? '0 : rd_q.pressure;
      res_r.cur_vibration   <= empty ? '0 : rd_q.vibration;
      res_r.cur_stamp       <= empty ? '0 : rd_q.stamp;
      res_r.position        <= empty ? '0 : pos_wide[POS_W-1:0];
      res_r.record_count    <= cnt_wide[POS_W-1:0];
    end
  end

  assign out_word = res_r;

endmodule

FILE: sv/history_buffer_with_cursor.sv
// Top level of the sensor history buffer: controller, datapath and channel ports.
// Depends on hbc_pkg, hbc_if, hbc_ctrl and hbc_dpath.
//
// Keeps the last CAPACITY sensor records in a ring, oldest to newest, with a
// browse cursor; every command word returns exactly one result word carrying the
// status, the record under the cursor, its one-based position and the count.
// Each command passes through the accept, the pointer update with the store
// write, the read of the record memory at the new cursor, and the load of the
// result register, which waits until the previous result has been taken. The
// next command is accepted in the cycle after that load, while the previous
// result may still wait in the result register; no command is accepted before
// the previous one is loaded. The record memory has a single read port, read
// after the update. Record entries are undefined until written and are never
// cleared; position and record_count are reported modulo 64.
module history_buffer_with_cursor import hbc_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input logic       clk,
  input logic       rst_n,
  hbc_in_if.sink    in_chan,
  hbc_out_if.source out_chan
);

  hbc_cmd_t cmd;

  hbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  hbc_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_chan.payload),
    .out_word (out_chan.payload)
  );

  // Only one command is in flight: no new word straight after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input accepted while a command was in flight");

  // A result names a record exactly when records are held.
  a_has_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (CAPACITY < 64)) |->
      (out_chan.payload.has_record == (out_chan.payload.record_count != '0)))
    else $error("has_record disagrees with record_count");

  // An empty result carries no record and no position.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.payload.has_record) |->
      ((out_chan.payload.position == '0) && (out_chan.payload.cur_stamp == '0)))
    else $error("empty result carries record data");

  // The cursor lies within the held records and the count within the capacity.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (CAPACITY < 64)) |->
      ((out_chan.payload.position <= out_chan.payload.record_count) &&
       (32'(out_chan.payload.record_count) <= 32'(CAPACITY))))
    else $error("position or count out of range");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for the sensor history buffer: drives command words, predicts each cursor report
// and compares it field by field. Depends on hbc_pkg, hbc_if and history_buffer_with_cursor.
module tb;
  import hbc_pkg::*;

  localparam int RING_SLOTS    = 32;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int QUIET_FIRST   = 300;
  localparam int QUIET_LAST    = 450;
  localparam int HOLDOFF_AFTER = 600;
  localparam int HOLDOFF_LEN   = 150;
  localparam int DRAIN_AT_A    = 25;
  localparam int DRAIN_AT_B    = 800;
  localparam int MAX_REPORTS   = 10;

  // Operation codes outside the package list; the block treats them as show.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic clk;
  logic rst_n;

  hbc_in_if  cmd_chan ();
  hbc_out_if report_chan ();

  history_buffer_with_cursor #(.CAPACITY(RING_SLOTS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cmd_chan),
    .out_chan (report_chan)
  );

  // Command words still to be sent and cursor reports still to arrive.
  in_word_t  queued_commands[$];
  out_word_t predicted_reports[$];

  // Shadow copy of the ring and its pointers.
  rec_t ring_copy [RING_SLOTS];
  int   oldest_idx = 0;
  int   held_records = 0;
  int   cursor_idx = 0;

  int words_sent = 0;
  int reports_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic holdoff_active;
  logic holdoff_done;
  int   holdoff_cycles;

  // Clock: 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Applies one command word to the shadow ring and returns the report it should produce.
  function automatic out_word_t predict_cursor_report(in_word_t w);
    out_word_t rep;
    rec_t      fresh;
    status_t   st;
    st = STS_OK;
    fresh.node_id     = w.node_id;
    fresh.temperature = w.temperature;
    fresh.humidity    = w.humidity;
    fresh.pressure    = w.pressure;
    fresh.vibration   = w.vibration;
    fresh.stamp       = w.stamp;
    case (w.operation)
      OP_APPEND: begin
        if (held_records == 0) begin
          ring_copy[oldest_idx] = fresh;
          cursor_idx = oldest_idx;
          held_records = 1;
        end else if (held_records < RING_SLOTS) begin
          ring_copy[(oldest_idx + held_records) % RING_SLOTS] = fresh;
          held_records++;
        end else begin
          // Full ring: the oldest record is overwritten and the cursor follows if it stood there.
          ring_copy[oldest_idx] = fresh;
          if (cursor_idx == oldest_idx) cursor_idx = (oldest_idx + 1) % RING_SLOTS;
          oldest_idx = (oldest_idx + 1) % RING_SLOTS;
          st = STS_EVICTED;
        end
      end
      OP_NEWER: begin
        if (held_records == 0) st = STS_EMPTY;
        else if (cursor_idx == (oldest_idx + held_records - 1) % RING_SLOTS) st = STS_AT_END;
        else cursor_idx = (cursor_idx + 1) % RING_SLOTS;
      end
      OP_OLDER: begin
        if (held_records == 0) st = STS_EMPTY;
        else if (cursor_idx == oldest_idx) st = STS_AT_END;
        else cursor_idx = (cursor_idx + RING_SLOTS - 1) % RING_SLOTS;
      end
      OP_CLEAR: begin
        held_records = 0;
        oldest_idx = 0;
        cursor_idx = 0;
      end
      default: begin
        if (held_records == 0) st = STS_EMPTY;
      end
    endcase
    rep = '0;
    rep.status = st;
    if (held_records != 0) begin
      rep.has_record      = 1'b1;
      rep.cur_node_id     = ring_copy[cursor_idx].node_id;
      rep.cur_temperature = ring_copy[cursor_idx].temperature;
      rep.cur_humidity    = ring_copy[cursor_idx].humidity;
      rep.cur_pressure    = ring_copy[cursor_idx].pressure;
      rep.cur_vibration   = ring_copy[cursor_idx].vibration;
      rep.cur_stamp       = ring_copy[cursor_idx].stamp;
      rep.position = POS_W'((cursor_idx + RING_SLOTS - oldest_idx) % RING_SLOTS + 1);
    end
    rep.record_count = POS_W'(held_records);
    return rep;
  endfunction

  // Compares one field; reports it while the report budget lasts.
  task automatic compare_field(string fname, logic [31:0] want, logic [31:0] got,
                               inout int nbad);
    if (got !== want) begin
      nbad++;
      if (mismatch_count < MAX_REPORTS)
        $display("Mismatch on report %0d, %s: expected %h, got %h",
                 reports_seen, fname, want, got);
    end
  endtask

  task automatic check_report(out_word_t want, out_word_t got);
    int nbad;
    nbad = 0;
    compare_field("status", want.status, got.status, nbad);
    compare_field("has_record", want.has_record, got.has_record, nbad);
    compare_field("cur_node_id", want.cur_node_id, got.cur_node_id, nbad);
    compare_field("cur_temperature", want.cur_temperature, got.cur_temperature, nbad);
    compare_field("cur_humidity", want.cur_humidity, got.cur_humidity, nbad);
    compare_field("cur_pressure", want.cur_pressure, got.cur_pressure, nbad);
    compare_field("cur_vibration", want.cur_vibration, got.cur_vibration, nbad);
    compare_field("cur_stamp", want.cur_stamp, got.cur_stamp, nbad);
    compare_field("position", want.position, got.position, nbad);
    compare_field("record_count", want.record_count, got.record_count, nbad);
    if (nbad != 0) mismatch_count++;
  endtask

  // Field values with a bias towards the signed extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_command(logic [2:0] op, logic [15:0] id, logic [31:0] v1,
                               logic [31:0] v2, logic [31:0] v3, logic [31:0] v4,
                               logic [31:0] st);
    in_word_t w;
    w.operation   = op;
    w.node_id     = id;
    w.temperature = v1;
    w.humidity    = v2;
    w.pressure    = v3;
    w.vibration   = v4;
    w.stamp       = st;
    queued_commands.push_back(w);
  endtask

  task automatic queue_random(logic [2:0] op);
    queue_command(op, 16'($urandom_range(0, 65535)), pick_value(), pick_value(),
                  pick_value(), pick_value(), pick_value());
  endtask

  // Sender: offers the next word, pausing at random and twice until all reports are in.
  always @(posedge clk) begin
    logic quiet;
    logic drain_hold;
    if (!rst_n) begin
      cmd_chan.valid <= 1'b0;
    end else if (!cmd_chan.valid || cmd_chan.ready) begin
      if (cmd_chan.valid) begin
        predicted_reports.push_back(predict_cursor_report(cmd_chan.payload));
        words_sent++;
      end
      quiet = (words_sent >= QUIET_FIRST) && (words_sent < QUIET_LAST);
      drain_hold = (words_sent == DRAIN_AT_A || words_sent == DRAIN_AT_B) &&
                   (reports_seen != words_sent);
      if (queued_commands.size() != 0 && !drain_hold &&
          (quiet || $urandom_range(0, 99) >= 38)) begin
        cmd_chan.payload <= queued_commands.pop_front();
        cmd_chan.valid   <= 1'b1;
      end else begin
        cmd_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each accepted report and stalls at random or during the hold-off.
  always @(posedge clk) begin
    logic quiet;
    if (!rst_n) begin
      report_chan.ready <= 1'b0;
    end else begin
      if (report_chan.valid && report_chan.ready) begin
        if (predicted_reports.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("Unexpected report word: %p", report_chan.payload);
          mismatch_count++;
        end else begin
          check_report(predicted_reports.pop_front(), report_chan.payload);
        end
        reports_seen <= reports_seen + 1;
      end
      quiet = (reports_seen >= QUIET_FIRST) && (reports_seen < QUIET_LAST);
      report_chan.ready <= !holdoff_active && (quiet || $urandom_range(0, 99) >= 38);
    end
  end

  // One long receiver hold-off so that the block fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      holdoff_active <= 1'b0;
      holdoff_done   <= 1'b0;
      holdoff_cycles <= 0;
    end else if (!holdoff_done) begin
      if (!holdoff_active && reports_seen >= HOLDOFF_AFTER) begin
        holdoff_active <= 1'b1;
      end else if (holdoff_active) begin
        if (holdoff_cycles == HOLDOFF_LEN) begin
          holdoff_active <= 1'b0;
          holdoff_done   <= 1'b1;
        end
        holdoff_cycles <= holdoff_cycles + 1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int append_pct;
    int pick;
    logic [2:0] op;
    rst_n = 1'b0;
    append_pct = 50;

    // Directed part: empty ring, field extremes, both ends, unused codes and clear.
    queue_random(OP_SHOW);
    queue_random(OP_NEWER);
    queue_random(OP_OLDER);
    queue_random(OP_SPARE_5);
    queue_command(OP_APPEND, 16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h0000_0000);
    queue_random(OP_NEWER);
    queue_random(OP_OLDER);
    queue_command(OP_APPEND, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_command(OP_APPEND, 16'h5A5A, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                  32'hFFFF_FFFE, 32'h8000_0000);
    queue_random(OP_OLDER);
    queue_random(OP_NEWER);
    queue_random(OP_NEWER);
    queue_random(OP_NEWER);
    queue_random(OP_OLDER);
    queue_random(OP_SPARE_6);
    queue_random(OP_SPARE_7);
    queue_random(OP_SHOW);
    queue_random(OP_CLEAR);
    queue_random(OP_SHOW);
    queue_random(OP_OLDER);
    queue_random(OP_CLEAR);
    queue_random(OP_APPEND);
    queue_random(OP_SHOW);

    // Random part in phases of differing append weight, so the ring fills and wraps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: append_pct = 15;
          1: append_pct = 50;
          2: append_pct = 80;
          default: append_pct = 100;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        op = OP_CLEAR;
      end else if (pick < append_pct) begin
        op = OP_APPEND;
      end else begin
        case ($urandom_range(0, 11))
          0, 1, 2, 3: op = OP_NEWER;
          4, 5, 6, 7: op = OP_OLDER;
          8: op = OP_SHOW;
          9: op = OP_SPARE_5;
          10: op = OP_SPARE_6;
          default: op = OP_SPARE_7;
        endcase
      end
      queue_random(op);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word is sent and every report has arrived, then let the block settle.
    do @(negedge clk);
    while (!(queued_commands.size() == 0 && !cmd_chan.valid && reports_seen == words_sent));
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (predicted_reports.size() != 0) begin
      $display("%0d report words never arrived", predicted_reports.size());
    end
    if (mismatch_count == 0 && predicted_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
